@@ rtl/rpn_pkg.sv @@
// Shared types and constants for the postfix expression evaluator.
package rpn_pkg;

    localparam int SYMBOL_W      = 8;
    localparam int VALUE_OUT_W   = 32;
    localparam int ERR_W         = 2;
    localparam int DIGIT_W       = 4;
    localparam int STACK_DEPTH_D = 16;
    localparam int VALUE_WIDTH_D = 32;
    // Command queue depth, a power of two
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_DIVZ  = 2'd2,
        ERR_OVER  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [DIGIT_W-1:0]   digit;
        logic                 last;
    } cmd_t;

endpackage

@@ rtl/rpn_sym_if.sv @@
// Input channel: one expression character per beat.
interface rpn_sym_if;
    logic                          valid;
    logic                          ready;
    logic [rpn_pkg::SYMBOL_W-1:0]  symbol;
    logic                          last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

@@ rtl/rpn_res_if.sv @@
// Result channel: top of stack and error code per expression.
interface rpn_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rpn_pkg::VALUE_OUT_W-1:0] value;
    logic [rpn_pkg::ERR_W-1:0]             error_code;

    modport source (output valid, output value, output error_code, input ready);
    modport sink   (input valid, input value, input error_code, output ready);
endinterface

@@ rtl/rpn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/rpn_front.sv @@
// Front end: accept characters, classify them, drop ignored ones.
module rpn_front (
    input  logic              clk,
    input  logic              rst_n,
    rpn_sym_if.sink           sym,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output rpn_pkg::cmd_t     cmd
);

    rpn_pkg::cmd_t cls;
    logic          valid_reg;
    logic          valid_next;
    rpn_pkg::cmd_t cmd_reg;
    logic          fire;
    logic          keep;

    always_comb
    begin
        cls.kind  = rpn_pkg::OP_NOP;
        cls.digit = sym.symbol[rpn_pkg::DIGIT_W-1:0];
        cls.last  = sym.last_symbol;
        unique case (sym.symbol) inside
            [rpn_pkg::CH_ZERO:rpn_pkg::CH_NINE]: cls.kind = rpn_pkg::OP_PUSH;
            rpn_pkg::CH_PLUS:                    cls.kind = rpn_pkg::OP_ADD;
            rpn_pkg::CH_MINUS:                   cls.kind = rpn_pkg::OP_SUB;
            rpn_pkg::CH_STAR:                    cls.kind = rpn_pkg::OP_MUL;
            rpn_pkg::CH_SLASH:                   cls.kind = rpn_pkg::OP_DIV;
            default:                             cls.kind = rpn_pkg::OP_NOP;
        endcase
    end

    assign sym.ready = !valid_reg || cmd_ready;
    assign fire      = sym.valid && sym.ready;
    // Drop characters that do nothing unless they close the expression
    assign keep      = (cls.kind != rpn_pkg::OP_NOP) || cls.last;

    always_comb
    begin
        if (fire)
        begin
            valid_next = keep;
        end
        else
        begin
            valid_next = valid_reg && !cmd_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cmd_reg <= cls;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

@@ rtl/rpn_queue.sv @@
// Short command queue between front end and execution unit.
module rpn_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rpn_pkg::cmd_t     in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output rpn_pkg::cmd_t     out_cmd
);

    localparam int QAW = $clog2(rpn_pkg::QUEUE_DEPTH);

    rpn_pkg::cmd_t    slots [rpn_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]   wptr_reg;
    logic [QAW-1:0]   rptr_reg;
    logic [QAW:0]     count_reg;
    logic [QAW-1:0]   wptr_next;
    logic [QAW-1:0]   rptr_next;
    logic [QAW:0]     count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != (QAW+1)'(rpn_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slots[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wptr_reg] <= in_cmd;
        end
    end

endmodule

@@ rtl/rpn_back.sv @@
// Execution unit: operand stack, shift-add multiplier, restoring divider.
module rpn_back #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_D,
    parameter int VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_D
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rpn_pkg::cmd_t     cmd,
    rpn_res_if.source         res
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CW  = $clog2(VALUE_WIDTH);
    localparam int VW  = VALUE_WIDTH;
    localparam int OW  = rpn_pkg::VALUE_OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    rpn_pkg::err_t        sticky_reg, sticky_next;
    rpn_pkg::op_kind_t    kind_reg, kind_next;
    logic                 last_reg, last_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    logic [VW-1:0]        tos_reg, tos_next;
    logic [VW-1:0]        acc_reg, acc_next;
    logic [VW-1:0]        mcand_reg, mcand_next;
    logic [VW-1:0]        mplier_reg, mplier_next;
    logic [VW-1:0]        rem_reg, rem_next;
    logic [VW-1:0]        quo_reg, quo_next;
    logic [VW-1:0]        dm_reg, dm_next;
    logic                 neg_reg, neg_next;
    logic [OW-1:0]        value_reg, value_next;
    rpn_pkg::err_t        err_reg, err_next;

    logic                 ram_we;
    logic [VW-1:0]        ram_rdata;
    logic [SPW-1:0]       sp_m1;
    logic [SPW-1:0]       sp_m2;
    logic [VW-1:0]        acc_step;
    logic [VW:0]          rem_sh;
    logic [VW:0]          div_sub;
    logic                 div_ge;
    logic [VW-1:0]        a_abs;
    logic [VW-1:0]        b_abs;
    state_t               after_op;

    function automatic rpn_pkg::err_t note_err(rpn_pkg::err_t held, rpn_pkg::err_t code);
        return (held == rpn_pkg::ERR_NONE) ? code : held;
    endfunction

    assign sp_m1    = sp_reg - SPW'(1);
    assign sp_m2    = sp_reg - SPW'(2);
    assign after_op = last_reg ? ST_FIN : ST_IDLE;

    assign acc_step = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign rem_sh   = {rem_reg, quo_reg[VW-1]};
    assign div_ge   = rem_sh >= {1'b0, dm_reg};
    assign div_sub  = rem_sh - {1'b0, dm_reg};
    assign a_abs    = ram_rdata[VW-1] ? (VW'(0) - ram_rdata) : ram_rdata;
    assign b_abs    = tos_reg[VW-1] ? (VW'(0) - tos_reg) : tos_reg;

    rpn_ram #(
        .WIDTH (VW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sp_m1[AW-1:0]),
        .wdata (tos_reg),
        .raddr (sp_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        sticky_next    = sticky_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !res.ready;
        tos_next       = tos_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dm_next        = dm_reg;
        neg_next       = neg_reg;
        value_next     = value_reg;
        err_next       = err_reg;
        ram_we         = 1'b0;
        cmd_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    kind_next  = cmd.kind;
                    last_next  = cmd.last;
                    state_next = cmd.last ? ST_FIN : ST_IDLE;
                    unique case (cmd.kind) inside
                        rpn_pkg::OP_PUSH:
                        begin
                            if (sp_reg == SPW'(STACK_DEPTH))
                            begin
                                sticky_next = note_err(sticky_reg, rpn_pkg::ERR_OVER);
                            end
                            else
                            begin
                                // Spill the cached top into the RAM, keep the new digit in the register
                                ram_we   = sp_reg != '0;
                                tos_next = VW'(cmd.digit);
                                sp_next  = sp_reg + SPW'(1);
                            end
                        end
                        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV:
                        begin
                            if (sp_reg < SPW'(2))
                            begin
                                sticky_next = note_err(sticky_reg, rpn_pkg::ERR_UNDER);
                            end
                            else if ((cmd.kind == rpn_pkg::OP_DIV) && (tos_reg == '0))
                            begin
                                sticky_next = note_err(sticky_reg, rpn_pkg::ERR_DIVZ);
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                unique case (kind_reg) inside
                    rpn_pkg::OP_ADD:
                    begin
                        tos_next   = ram_rdata + tos_reg;
                        sp_next    = sp_m1;
                        state_next = after_op;
                    end
                    rpn_pkg::OP_SUB:
                    begin
                        tos_next   = ram_rdata - tos_reg;
                        sp_next    = sp_m1;
                        state_next = after_op;
                    end
                    rpn_pkg::OP_MUL:
                    begin
                        acc_next    = '0;
                        mcand_next  = ram_rdata;
                        mplier_next = tos_reg;
                        cnt_next    = CW'(VW - 1);
                        state_next  = ST_MUL;
                    end
                    rpn_pkg::OP_DIV:
                    begin
                        neg_next   = ram_rdata[VW-1] ^ tos_reg[VW-1];
                        quo_next   = a_abs;
                        dm_next    = b_abs;
                        rem_next   = '0;
                        cnt_next   = CW'(VW - 1);
                        state_next = ST_DIV;
                    end
                    default:
                    begin
                        state_next = after_op;
                    end
                endcase
            end

            ST_MUL:
            begin
                acc_next    = acc_step;
                mcand_next  = {mcand_reg[VW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[VW-1:1]};
                cnt_next    = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    tos_next   = acc_step;
                    sp_next    = sp_m1;
                    state_next = after_op;
                end
            end

            ST_DIV:
            begin
                rem_next = div_ge ? div_sub[VW-1:0] : rem_sh[VW-1:0];
                quo_next = {quo_reg[VW-2:0], div_ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
            end

            ST_FIX:
            begin
                tos_next   = neg_reg ? (VW'(0) - quo_reg) : quo_reg;
                sp_next    = sp_m1;
                state_next = after_op;
            end

            ST_FIN:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    if (sp_reg == '0)
                    begin
                        value_next = '0;
                        err_next   = note_err(sticky_reg, rpn_pkg::ERR_UNDER);
                    end
                    else
                    begin
                        value_next = OW'(tos_reg);
                        err_next   = sticky_reg;
                    end
                    sp_next     = '0;
                    sticky_next = rpn_pkg::ERR_NONE;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            sticky_reg    <= rpn_pkg::ERR_NONE;
            kind_reg      <= rpn_pkg::OP_NOP;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            sticky_reg    <= sticky_next;
            kind_reg      <= kind_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg    <= tos_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dm_reg     <= dm_next;
        neg_reg    <= neg_next;
        value_reg  <= value_next;
        err_reg    <= err_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.value      = signed'(value_reg);
    assign res.error_code = err_reg;

endmodule

@@ rtl/postfix_expression_evaluator_top.sv @@
// Top level of the postfix expression evaluator.
//
//  Port  | Direction | Beat carries                  | Handshake
//  ------+-----------+-------------------------------+-------------
//  sym   | in        | symbol[7:0], last_symbol      | valid/ready
//  res   | out       | value[31:0] signed, error_code| valid/ready
//
// In the execution unit a digit is taken in the idle state; add and subtract also pass the
// read state; multiply and divide then run one-bit-per-cycle loops, divide with a sign fix-up;
// other characters are dropped in the front end unless they close the expression,
// and a closing character also goes through the final state, which emits the result.
// Reset is asynchronous, active low, and empties stack, queue and result. The queue lets
// the front end run ahead of the loops; a held result stalls only the next closing character.
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_D,
    parameter int VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_D
) (
    input  logic      clk,
    input  logic      rst_n,
    rpn_sym_if.sink   sym,
    rpn_res_if.source res
);

    // Front end to queue
    logic          f_valid;
    logic          f_ready;
    rpn_pkg::cmd_t f_cmd;

    // Queue to execution unit
    logic          q_valid;
    logic          q_ready;
    rpn_pkg::cmd_t q_cmd;

    // Classify each beat; drop characters that are neither digit nor operator unless they close the expression
    rpn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym       (sym),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    // Hold decoded commands while the execution unit is busy
    rpn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // Advance the stack, run the arithmetic, emit one result per expression
    rpn_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res       (res)
    );

endmodule

@@ rtl/rpn_checker.sv @@
// Port-level checks for the postfix expression evaluator, bound to the top.
module rpn_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sym_valid,
    input logic                              sym_ready,
    input logic                              sym_last,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [rpn_pkg::VALUE_OUT_W-1:0]   res_value,
    input logic [rpn_pkg::ERR_W-1:0]         res_error_code
);

    // Expressions closed at the input but not yet delivered
    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       in_last_fire;
    logic       out_fire;

    assign in_last_fire = sym_valid && sym_ready && sym_last;
    assign out_fire     = res_valid && res_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_last_fire && !out_fire)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (out_fire && !in_last_fire)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_value) && $stable(res_error_code))
        else $error("result payload changed while stalled");

    a_res_owed: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> pend_reg != 3'd0)
        else $error("result without a closed expression");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd5)
        else $error("more open results than the pipeline can hold");

endmodule

bind postfix_expression_evaluator_top rpn_checker u_rpn_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sym_valid      (sym.valid),
    .sym_ready      (sym.ready),
    .sym_last       (sym.last_symbol),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_value      (res.value),
    .res_error_code (res.error_code)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the postfix expression evaluator top level.
module testbench;
    import rpn_pkg::*;

    // Cycles with no beat on either channel before the run is abandoned. The
    // slowest correct stretch is a few queued divides plus a long stall on
    // each side, well under this figure.
    localparam int STALL_LIMIT  = 3000;
    // Quiet cycles after the last result, enough for a queue of divides.
    localparam int DRAIN_CYCLES = 200;
    localparam int TOTAL_BEATS  = 450;
    localparam int N_DIRECTED   = 27;

    typedef struct packed {
        logic signed [VALUE_OUT_W-1:0] value;
        err_t                          err;
    } result_t;

    typedef struct {
        logic [SYMBOL_W-1:0] ch;
        logic                last;
        bit                  typed;
        result_t             known;
    } stim_row_t;

    localparam result_t NO_RESULT = '{value: '0, err: ERR_NONE};

    logic clk = 1'b0;
    logic rst_n;

    rpn_sym_if sym_ch ();
    rpn_res_if res_ch ();

    postfix_expression_evaluator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sym   (sym_ch),
        .res   (res_ch)
    );

    always #2 clk = ~clk;

    // Directed table. Rows with a typed result are simple enough to read off
    // by eye; the rest take their result from the operand stack model below.
    stim_row_t directed_rows [N_DIRECTED] = '{
        // Single digits at both ends of the range
        '{CH_NINE,          1'b1, 1'b1, '{32'sd9, ERR_NONE}},
        '{CH_ZERO,          1'b1, 1'b1, '{32'sd0, ERR_NONE}},
        // Stray characters just above nine and at the top of the byte: neither
        // pushes anything, so the final character finds an empty stack
        '{CH_NINE + 8'd1,   1'b0, 1'b0, NO_RESULT},
        '{8'hFF,            1'b1, 1'b1, '{32'sd0, ERR_UNDER}},
        // Operator with nothing to pop
        '{CH_PLUS,          1'b1, 1'b1, '{32'sd0, ERR_UNDER}},
        // 7 - 3
        '{CH_ZERO + 8'd7,   1'b0, 1'b0, NO_RESULT},
        '{CH_ZERO + 8'd3,   1'b0, 1'b0, NO_RESULT},
        '{CH_MINUS,         1'b1, 1'b1, '{32'sd4, ERR_NONE}},
        // 9 * 9
        '{CH_NINE,          1'b0, 1'b0, NO_RESULT},
        '{CH_NINE,          1'b0, 1'b0, NO_RESULT},
        '{CH_STAR,          1'b1, 1'b1, '{32'sd81, ERR_NONE}},
        // (0 - 5) / 2: negative dividend, truncation toward zero
        '{CH_ZERO,          1'b0, 1'b0, NO_RESULT},
        '{CH_ZERO + 8'd5,   1'b0, 1'b0, NO_RESULT},
        '{CH_MINUS,         1'b0, 1'b0, NO_RESULT},
        '{CH_ZERO + 8'd2,   1'b0, 1'b0, NO_RESULT},
        '{CH_SLASH,         1'b1, 1'b0, NO_RESULT},
        // 8 / 0: divide skipped, zero stays on top
        '{CH_ZERO + 8'd8,   1'b0, 1'b0, NO_RESULT},
        '{CH_ZERO,          1'b0, 1'b0, NO_RESULT},
        '{CH_SLASH,         1'b1, 1'b1, '{32'sd0, ERR_DIVZ}},
        // Underflow first, then divide by zero: the first error is kept
        '{CH_ZERO + 8'd5,   1'b0, 1'b0, NO_RESULT},
        '{CH_MINUS,         1'b0, 1'b0, NO_RESULT},
        '{CH_ZERO,          1'b0, 1'b0, NO_RESULT},
        '{CH_SLASH,         1'b1, 1'b1, '{32'sd0, ERR_UNDER}},
        // 1 + 2 with an all-zero byte dropped in between
        '{CH_ZERO + 8'd1,   1'b0, 1'b0, NO_RESULT},
        '{8'h00,            1'b0, 1'b0, NO_RESULT},
        '{CH_ZERO + 8'd2,   1'b0, 1'b0, NO_RESULT},
        '{CH_PLUS,          1'b1, 1'b0, NO_RESULT}
    };

    // Operand stack model
    logic [VALUE_OUT_W-1:0] calc_stack [STACK_DEPTH_D];
    int                     calc_depth = 0;
    err_t                   held_err   = ERR_NONE;

    result_t             pending_results [$];
    logic [SYMBOL_W-1:0] expr_chars [$];

    int  failures        = 0;
    int  results_checked = 0;
    int  beats_in        = 0;
    int  random_beats    = 0;
    int  expressions     = 0;
    int  err_seen [4]    = '{0, 0, 0, 0};
    int  idle_cycles     = 0;
    bit  full_rate       = 1'b0;

    function automatic bit is_digit(input logic [SYMBOL_W-1:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic bit is_operator(input logic [SYMBOL_W-1:0] ch);
        return ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH;
    endfunction

    function automatic void note_error(input err_t code);
        if (held_err == ERR_NONE)
            held_err = code;
    endfunction

    // Advance the stack model by one accepted character; hand back the
    // result that the character closes, if it is the last of its expression.
    function automatic void evaluate_symbol(input logic [SYMBOL_W-1:0] ch, input logic last,
                                            output bit has_result, output result_t outcome);
        logic [VALUE_OUT_W-1:0] a, b, r, mag_a, mag_b, quot;
        has_result = 1'b0;
        outcome    = NO_RESULT;
        if (is_digit(ch))
        begin
            if (calc_depth >= STACK_DEPTH_D)
            begin
                note_error(ERR_OVER);
            end
            else
            begin
                calc_stack[calc_depth] = VALUE_OUT_W'(ch - CH_ZERO);
                calc_depth++;
            end
        end
        else if (is_operator(ch))
        begin
            if (calc_depth < 2)
            begin
                note_error(ERR_UNDER);
            end
            else
            begin
                b = calc_stack[calc_depth-1];
                a = calc_stack[calc_depth-2];
                if (ch == CH_SLASH && b == '0)
                begin
                    note_error(ERR_DIVZ);
                end
                else
                begin
                    case (ch)
                        CH_PLUS:  r = a + b;
                        CH_MINUS: r = a - b;
                        CH_STAR:  r = a * b;
                        default:
                        begin
                            // Divide magnitudes, then fix the sign; the most
                            // negative value over -1 wraps back onto itself
                            mag_a = a[VALUE_OUT_W-1] ? -a : a;
                            mag_b = b[VALUE_OUT_W-1] ? -b : b;
                            quot  = mag_a / mag_b;
                            r     = (a[VALUE_OUT_W-1] ^ b[VALUE_OUT_W-1]) ? -quot : quot;
                        end
                    endcase
                    calc_depth--;
                    calc_stack[calc_depth-1] = r;
                end
            end
        end
        if (last)
        begin
            if (calc_depth == 0)
                note_error(ERR_UNDER);
            else
                outcome.value = calc_stack[calc_depth-1];
            outcome.err = held_err;
            has_result  = 1'b1;
            calc_depth  = 0;
            held_err    = ERR_NONE;
        end
    endfunction

    // Mostly back-to-back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (full_rate || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [SYMBOL_W-1:0] pick_digit(input int lo);
        return CH_ZERO + SYMBOL_W'($urandom_range(lo, 9));
    endfunction

    function automatic logic [SYMBOL_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Any byte that the block drops
    function automatic logic [SYMBOL_W-1:0] pick_stray();
        logic [SYMBOL_W-1:0] ch;
        do
            ch = SYMBOL_W'($urandom_range(0, 255));
        while (is_digit(ch) || is_operator(ch));
        return ch;
    endfunction

    // Well-formed expression of up to eight operands, with the odd stray byte
    function automatic void build_wellformed();
        int operands, pushed, depth;
        expr_chars.delete();
        operands = $urandom_range(1, 8);
        pushed   = 0;
        depth    = 0;
        while (pushed < operands || depth > 1)
        begin
            if ($urandom_range(0, 11) == 0)
                expr_chars.push_back(pick_stray());
            if (pushed < operands && (depth < 2 || $urandom_range(0, 2) != 0))
            begin
                expr_chars.push_back(pick_digit(0));
                depth++;
                pushed++;
            end
            else
            begin
                expr_chars.push_back(pick_operator());
                depth--;
            end
        end
    endfunction

    // Fill the stack to around its depth, often past it, then fold it up
    function automatic void build_deep();
        int pushes, ops;
        expr_chars.delete();
        pushes = $urandom_range(STACK_DEPTH_D - 2, STACK_DEPTH_D + 3);
        ops    = $urandom_range(pushes - 3, pushes + 1);
        repeat (pushes)
            expr_chars.push_back(pick_digit(1));
        repeat (ops)
            expr_chars.push_back($urandom_range(0, 3) != 0 ? CH_STAR : pick_operator());
    endfunction

    // Random mix of digits, operators and stray bytes
    function automatic void build_broken();
        int len;
        expr_chars.delete();
        len = $urandom_range(1, 10);
        repeat (len)
        begin
            case ($urandom_range(0, 4))
                0, 1:    expr_chars.push_back(pick_digit(0));
                2, 3:    expr_chars.push_back(pick_operator());
                default: expr_chars.push_back(SYMBOL_W'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // 8^10 * 2 is the most negative value; divide it by (0 - 1)
    function automatic void build_min_over_minus_one();
        expr_chars.delete();
        repeat (10)
            expr_chars.push_back(CH_ZERO + 8'd8);
        expr_chars.push_back(CH_ZERO + 8'd2);
        repeat (10)
            expr_chars.push_back(CH_STAR);
        expr_chars.push_back(CH_ZERO);
        expr_chars.push_back(CH_ZERO + 8'd1);
        expr_chars.push_back(CH_MINUS);
        expr_chars.push_back(CH_SLASH);
    endfunction

    // Present one beat after a random gap and hold it until it is taken.
    // Inputs change only at the falling edge; acceptance is judged at the
    // rising edge, before the block's own registers update.
    task automatic send_symbol(input logic [SYMBOL_W-1:0] ch, input logic last,
                               input bit typed, input result_t known);
        int      gap;
        bit      has_result;
        result_t predicted;
        gap = pick_gap();
        @(negedge clk);
        repeat (gap)
        begin
            sym_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sym_ch.valid       <= 1'b1;
        sym_ch.symbol      <= ch;
        sym_ch.last_symbol <= last;
        do
            @(posedge clk);
        while (!sym_ch.ready);
        beats_in++;
        evaluate_symbol(ch, last, has_result, predicted);
        if (has_result)
            pending_results.push_back(typed ? known : predicted);
    endtask

    // Send the built expression, marking its final character
    task automatic send_expression();
        foreach (expr_chars[i])
        begin
            send_symbol(expr_chars[i], i == expr_chars.size() - 1, 1'b0, NO_RESULT);
            if (is_digit(expr_chars[i]) || is_operator(expr_chars[i]))
                random_beats++;
        end
        expressions++;
    endtask

    // Result side back-pressure: drop ready for a random hold after each cycle
    initial
    begin
        int hold;
        hold         = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // Compare every result beat with the oldest outstanding prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing outstanding: value %0d error_code %0d",
                       res_ch.value, res_ch.error_code);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                err_seen[want.err]++;
                if (res_ch.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, res_ch.value);
                    failures++;
                end
                if (res_ch.error_code !== want.err)
                begin
                    $error("error_code: expected %0d, got %0d", want.err, res_ch.error_code);
                    failures++;
                end
            end
        end
    end

    // Watchdog: abandon the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_results.size());
            $display("postfix_expression_evaluator_top verification failed");
            $finish;
        end
    end

    initial
    begin
        int kind;
        rst_n              = 1'b0;
        sym_ch.valid       = 1'b0;
        sym_ch.symbol      = '0;
        sym_ch.last_symbol = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table first
        foreach (directed_rows[i])
            send_symbol(directed_rows[i].ch, directed_rows[i].last,
                        directed_rows[i].typed, directed_rows[i].known);

        // Force the rarer corners once before the random mix
        build_min_over_minus_one();
        send_expression();
        build_deep();
        send_expression();

        // Random part: mostly well-formed expressions with random content,
        // the rest deep stacks, broken sequences, the wrap corner and noise
        while (beats_in < TOTAL_BEATS)
        begin
            full_rate = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 65)
                build_wellformed();
            else if (kind < 77)
                build_deep();
            else if (kind < 90)
                build_broken();
            else if (kind < 93)
                build_min_over_minus_one();
            else
            begin
                expr_chars.delete();
                repeat ($urandom_range(1, 4))
                    expr_chars.push_back(SYMBOL_W'($urandom_range(0, 255)));
            end
            send_expression();
        end
        full_rate = 1'b0;
        @(negedge clk);
        sym_ch.valid <= 1'b0;

        // Drain: wait for every outstanding result, then let the block settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats (%0d directed, %0d operand/operator beats in %0d expressions)",
                 beats_in, N_DIRECTED, random_beats, expressions);
        $display("Checked %0d results: none %0d, underflow %0d, divide by zero %0d, overflow %0d",
                 results_checked, err_seen[ERR_NONE], err_seen[ERR_UNDER],
                 err_seen[ERR_DIVZ], err_seen[ERR_OVER]);
        if (failures == 0)
            $display("postfix_expression_evaluator_top verification clean");
        else
            $display("postfix_expression_evaluator_top verification failed");
        $finish;
    end

endmodule
